@@ sv/stq_pkg.sv @@
// Sorted timer queue: shared types, widths and codes.
// Used by stq_cell and sorted_timer_queue; depends on nothing.
package stq_pkg;

  localparam int DEPTH     = 16;
  localparam int TIME_BITS = 32;
  localparam int TAG_BITS  = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_CANCEL  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] expiry_time;
    logic [15:0] timer_tag;
    logic [31:0] now_ticks;
  } stq_req_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [15:0]      fired_tag;
    logic [31:0]      fired_expiry;
    logic             status;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] pending_count;
    logic             last_of_run;
  } stq_result_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [TAG_BITS-1:0]  tag;
  } stq_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic [1:0]           op;
    stq_entry_t           ins;
    stq_entry_t           recirc;
    logic                 keep;
    logic [TIME_BITS-1:0] now;
  } stq_ctrl_t;

endpackage

@@ sv/stq_cell.sv @@
// One slot of the sorted timer chain: holds a timer, inserts in order,
// shifts toward the head on rotate. Depends on stq_pkg.
module stq_cell import stq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  stq_ctrl_t  ctrl,
  input  logic       prev_valid,
  input  logic       prev_cond,
  input  stq_entry_t prev_entry,
  input  logic       next_valid,
  input  stq_entry_t next_entry,
  output logic       valid,
  output logic       cond,
  output stq_entry_t entry,
  output logic       due
);

  logic       valid_next;
  stq_entry_t entry_next;

  // at or past the insertion point
  assign cond = !valid || (entry.expiry > ctrl.ins.expiry);
  assign due  = valid && (entry.expiry != '0) && (entry.expiry <= ctrl.now);

  always_comb begin
    valid_next = valid;
    entry_next = entry;
    case (ctrl.op)
      OP_INSERT: begin
        if (prev_cond) begin
          valid_next = prev_valid;
          entry_next = prev_entry;
        end else if (cond) begin
          valid_next = 1'b1;
          entry_next = ctrl.ins;
        end
      end
      OP_ROTATE: begin
        if (next_valid) begin
          valid_next = 1'b1;
          entry_next = next_entry;
        end else if (valid) begin
          valid_next = ctrl.keep;
          entry_next = ctrl.recirc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    entry <= entry_next;
  end

endmodule

@@ sv/sorted_timer_queue.sv @@
// Sorted timer queue top level: command decode, rotation sequencer, results.
// Depends on stq_pkg and stq_cell.
//
// An add is taken while idle and its result appears on the next cycle;
// busy stays low, so adds can follow back to back. Cancel and tick rotate
// the cell chain one timer per cycle through the head cell: after the
// accepting cycle busy stays high until every pending timer has gone
// through the head cell; it never goes high when the queue is empty.
// Each result shows for exactly one cycle with done high; expired timers
// come out in list order, the last one of a tick marked by last_of_run.
// The receiver cannot stall: results must be captured on the cycle they
// appear.
module sorted_timer_queue import stq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  stq_req_t    request,
  output logic        done,
  output stq_result_t result
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROT  = 1'b1;
  localparam logic MODE_CANCEL = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  logic                 state;
  logic                 mode;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     steps;
  logic [CNT_W-1:0]     removed;
  logic                 fired;
  logic [TIME_BITS-1:0] now_r;
  logic [TAG_BITS-1:0]  tag_r;

  stq_ctrl_t  ctrl;
  logic       v   [DEPTH];
  logic       c   [DEPTH];
  stq_entry_t e   [DEPTH];
  logic [DEPTH-1:0] due;

  logic             accept;
  logic             drop;
  logic             rest_due;
  logic             final_step;
  logic [CNT_W-1:0] count_less;
  logic             done_next;
  stq_result_t      result_next;

  assign accept = start && !busy;
  assign busy   = (state == ST_ROT);

  assign drop = (mode == MODE_CANCEL) ? (e[0].tag == tag_r) : due[0];
  assign rest_due   = |due[DEPTH-1:1];
  assign final_step = (steps == CNT_W'(1));
  assign count_less = count - {{(CNT_W-1){1'b0}}, drop};

  always_comb begin
    ctrl.op = OP_HOLD;
    if (state == ST_ROT) begin
      ctrl.op = OP_ROTATE;
    end else if (accept && request.command == CMD_ADD && count < CNT_W'(DEPTH)) begin
      ctrl.op = OP_INSERT;
    end
    ctrl.ins.expiry = request.expiry_time[TIME_BITS-1:0];
    ctrl.ins.tag    = request.timer_tag[TAG_BITS-1:0];
    ctrl.recirc     = e[0];
    ctrl.keep       = !drop;
    ctrl.now        = now_r;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       pv;
    logic       pc;
    stq_entry_t pe;
    logic       nv;
    stq_entry_t ne;
    if (i == 0) begin : g_head
      assign pv = 1'b0;
      assign pc = 1'b0;
      assign pe = '0;
    end else begin : g_body
      assign pv = v[i-1];
      assign pc = c[i-1];
      assign pe = e[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nv = 1'b0;
      assign ne = '0;
    end else begin : g_mid
      assign nv = v[i+1];
      assign ne = e[i+1];
    end
    stq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (pv),
      .prev_cond  (pc),
      .prev_entry (pe),
      .next_valid (nv),
      .next_entry (ne),
      .valid      (v[i]),
      .cond       (c[i]),
      .entry      (e[i]),
      .due        (due[i])
    );
  end

  always_comb begin
    done_next   = 1'b0;
    result_next = result;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          result_next = '0;
          result_next.last_of_run = 1'b1;
          case (request.command)
            CMD_ADD: begin
              done_next = 1'b1;
              result_next.result_kind = KIND_ADD;
              if (count < CNT_W'(DEPTH)) begin
                result_next.pending_count = count + CNT_W'(1);
              end else begin
                result_next.status        = 1'b1;
                result_next.pending_count = count;
              end
            end
            CMD_CANCEL: begin
              if (count == '0) begin
                done_next = 1'b1;
                result_next.result_kind = KIND_CANCEL;
              end
            end
            CMD_TICK: begin
              if (count == '0) begin
                done_next = 1'b1;
                result_next.result_kind = KIND_NONE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROT: begin
        result_next = '0;
        result_next.pending_count = count_less;
        if (mode == MODE_CANCEL) begin
          if (final_step) begin
            done_next = 1'b1;
            result_next.result_kind   = KIND_CANCEL;
            result_next.removed_count = removed + {{(CNT_W-1){1'b0}}, drop};
            result_next.last_of_run   = 1'b1;
          end
        end else if (drop) begin
          done_next = 1'b1;
          result_next.result_kind  = KIND_EXPIRED;
          result_next.fired_tag    = 16'(e[0].tag);
          result_next.fired_expiry = 32'(e[0].expiry);
          result_next.last_of_run  = !rest_due;
        end else if (final_step && !fired) begin
          done_next = 1'b1;
          result_next.result_kind = KIND_NONE;
          result_next.last_of_run = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= done_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (request.command)
              CMD_ADD: begin
                if (count < CNT_W'(DEPTH)) begin
                  count <= count + CNT_W'(1);
                end
              end
              CMD_CANCEL: begin
                mode    <= MODE_CANCEL;
                tag_r   <= request.timer_tag[TAG_BITS-1:0];
                removed <= '0;
                steps   <= count;
                if (count != '0) begin
                  state <= ST_ROT;
                end
              end
              CMD_TICK: begin
                mode  <= MODE_TICK;
                now_r <= request.now_ticks[TIME_BITS-1:0];
                fired <= 1'b0;
                steps <= count;
                if (count != '0) begin
                  state <= ST_ROT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ROT: begin
          steps <= steps - CNT_W'(1);
          count <= count_less;
          if (drop) begin
            removed <= removed + CNT_W'(1);
            fired   <= 1'b1;
          end
          if (final_step) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    result <= result_next;
  end

endmodule
